@@ design/u8dec_pkg.sv @@
// UTF-8 code point decoder package: byte class constants, the result record
// and the lead byte classifier. No dependencies.
package u8dec_pkg;

    localparam int CP_W      = 21;
    localparam int HOLD_D    = 3;
    localparam int RES_MAX   = 4;
    localparam int FIFO_D    = 8;
    localparam int FIFO_AW   = $clog2(FIFO_D);
    localparam int FIFO_CW   = $clog2(FIFO_D + 1);

    // Sequence lengths; zero means not a lead byte (or nothing held)
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ASCII = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_VAL  = 8'h80;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            malformed;
        logic            run_last;
        logic            text_last;
    } result_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if (b[7] == 1'b0)
            len = LEN_ASCII;
        else if ((b & 8'hE0) == 8'hC0)
            len = LEN_TWO;
        else if ((b & 8'hF0) == 8'hE0)
            len = LEN_THREE;
        else if ((b & 8'hF8) == 8'hF0)
            len = LEN_FOUR;
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_VAL;
    endfunction

endpackage

@@ design/utf8_code_point_decoder_core.sv @@
// UTF-8 code point decoder top level: byte decode, sequence hold and an
// eight entry result queue. Depends on u8dec_pkg.
//
// One text byte is taken per cycle and decoded in the same cycle into zero to
// four results, which are written into an eight entry result queue; the
// output side drains one result per cycle while cp_stall is low. A byte whose
// sequence is broken or cut off by the end of text releases each held byte as
// a separate result, so the input is stalled whenever fewer than four queue
// entries are free. On well formed text with cp_stall low the sustained rate
// is one byte per cycle at the input and one result per cycle at the output;
// results are queued when the byte that completes them is accepted.
module utf8_code_point_decoder_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                in_byte,
    input  logic                      end_of_text,
    output logic                      cp_valid,
    input  logic                      cp_stall,
    output logic [u8dec_pkg::CP_W-1:0] code_point,
    output logic                      malformed,
    output logic                      run_last,
    output logic                      text_last
);

    // Sequence hold
    logic [7:0]                   held_reg [u8dec_pkg::HOLD_D];
    logic [1:0]                   held_cnt_reg, held_cnt_next;
    logic [2:0]                   seq_len_reg, seq_len_next;
    logic                         hold_we;
    logic [1:0]                   hold_idx;

    // Result queue
    u8dec_pkg::result_t           fifo_reg [u8dec_pkg::FIFO_D];
    logic [u8dec_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [u8dec_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [u8dec_pkg::FIFO_CW-1:0] count_reg, count_next;

    // Decode results
    u8dec_pkg::result_t           slot [u8dec_pkg::RES_MAX];
    logic [2:0]                   push_n;
    logic                         flush;
    logic                         extra_v;
    logic [u8dec_pkg::CP_W-1:0]   extra_cp;
    logic                         extra_bad;
    logic [2:0]                   len;
    logic                         accept;
    logic                         pop;

    assign accept     = byte_valid && !byte_stall;
    assign byte_stall = count_reg > u8dec_pkg::FIFO_CW'(u8dec_pkg::FIFO_D
                                                         - u8dec_pkg::RES_MAX);
    assign cp_valid   = count_reg != '0;
    assign pop        = cp_valid && !cp_stall;

    assign code_point = fifo_reg[rd_ptr_reg].code_point;
    assign malformed  = fifo_reg[rd_ptr_reg].malformed;
    assign run_last   = fifo_reg[rd_ptr_reg].run_last;
    assign text_last  = fifo_reg[rd_ptr_reg].text_last;

    always_comb
    begin
        held_cnt_next = held_cnt_reg;
        seq_len_next  = seq_len_reg;
        hold_we       = 1'b0;
        hold_idx      = 2'd0;
        flush         = 1'b0;
        extra_v       = 1'b0;
        extra_cp      = {13'd0, in_byte};
        extra_bad     = 1'b1;
        len           = u8dec_pkg::lead_len(in_byte);

        if (held_cnt_reg != 2'd0 && u8dec_pkg::is_cont(in_byte))
        begin
            if ({1'b0, held_cnt_reg} + 3'd1 == seq_len_reg)
            begin
                // Sequence complete: assemble the payload bits
                extra_v   = 1'b1;
                extra_bad = 1'b0;
                case (seq_len_reg)
                    u8dec_pkg::LEN_TWO:
                        extra_cp = {10'd0, held_reg[0][4:0], in_byte[5:0]};
                    u8dec_pkg::LEN_THREE:
                        extra_cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0],
                                    in_byte[5:0]};
                    default:
                        extra_cp = {held_reg[0][2:0], held_reg[1][5:0],
                                    held_reg[2][5:0], in_byte[5:0]};
                endcase
                held_cnt_next = 2'd0;
                seq_len_next  = u8dec_pkg::LEN_NONE;
            end
            else if (end_of_text || held_cnt_reg == 2'd3)
            begin
                flush         = 1'b1;
                extra_v       = 1'b1;
                held_cnt_next = 2'd0;
                seq_len_next  = u8dec_pkg::LEN_NONE;
            end
            else
            begin
                hold_we       = 1'b1;
                hold_idx      = held_cnt_reg;
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end
        else
        begin
            // No held sequence continues: release any held bytes, then decode this one fresh
            flush         = held_cnt_reg != 2'd0;
            held_cnt_next = 2'd0;
            seq_len_next  = u8dec_pkg::LEN_NONE;
            if (len == u8dec_pkg::LEN_ASCII)
            begin
                extra_v   = 1'b1;
                extra_bad = 1'b0;
            end
            else if (len == u8dec_pkg::LEN_NONE || end_of_text)
            begin
                extra_v = 1'b1;
            end
            else
            begin
                hold_we       = 1'b1;
                hold_idx      = 2'd0;
                held_cnt_next = 2'd1;
                seq_len_next  = len;
            end
        end

        push_n = (flush ? {1'b0, held_cnt_reg} : 3'd0) + {2'd0, extra_v};

        for (int i = 0; i < u8dec_pkg::RES_MAX; i++)
        begin
            if (flush && i < u8dec_pkg::HOLD_D && 3'(i) < {1'b0, held_cnt_reg})
            begin
                slot[i].code_point = {13'd0, held_reg[2'(i < u8dec_pkg::HOLD_D ?
                                                          i : 0)]};
                slot[i].malformed  = 1'b1;
            end
            else
            begin
                slot[i].code_point = extra_cp;
                slot[i].malformed  = extra_bad;
            end
            slot[i].run_last  = 3'(i) + 3'd1 == push_n;
            slot[i].text_last = (3'(i) + 3'd1 == push_n) && end_of_text;
        end

        wr_ptr_next = wr_ptr_reg;
        if (accept)
            wr_ptr_next = wr_ptr_reg + u8dec_pkg::FIFO_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + u8dec_pkg::FIFO_AW'(pop);
        count_next  = count_reg
                      + (accept ? u8dec_pkg::FIFO_CW'(push_n) : '0)
                      - u8dec_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            seq_len_reg  <= u8dec_pkg::LEN_NONE;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                held_cnt_reg <= held_cnt_next;
                seq_len_reg  <= seq_len_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_we)
            held_reg[hold_idx] <= in_byte;
        if (accept)
        begin
            for (int i = 0; i < u8dec_pkg::RES_MAX; i++)
            begin
                if (3'(i) < push_n)
                    fifo_reg[wr_ptr_reg + u8dec_pkg::FIFO_AW'(i)] <= slot[i];
            end
        end
    end

    // A hold always expects more bytes than it has
    a_hold_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg != 2'd0 |-> {1'b0, held_cnt_reg} < seq_len_reg)
        else $error("held byte count not below sequence length");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg == 2'd0 |-> seq_len_reg == u8dec_pkg::LEN_NONE)
        else $error("sequence length set with nothing held");

    // End of text leaves nothing held
    a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_text |=> held_cnt_reg == 2'd0)
        else $error("hold not cleared at end of text");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= u8dec_pkg::FIFO_CW'(u8dec_pkg::FIFO_D))
        else $error("result queue overflow");

endmodule
